@@ sv/wavelet_tree_level_builder_unit_assert.svh @@
// Assertion macros for the wavelet tree level builder.
`ifndef WAVELET_TREE_LEVEL_BUILDER_UNIT_ASSERT_SVH
`define WAVELET_TREE_LEVEL_BUILDER_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define WTLB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define WTLB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/wtlb_pkg.sv @@
//------------------------------------------------------------------------------
// wtlb_pkg
// Shared types and constants of the wavelet tree level builder.
//------------------------------------------------------------------------------
`default_nettype none
package wtlb_pkg;
   localparam int MaxTextLenDefault = 4096;
   localparam int SymbolBitsDefault = 8;
   localparam int WordBitsDefault   = 64;
   localparam int CsrBits           = 9;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] bit_word;
      logic [6:0]  bit_count;
      logic [2:0]  tree_level;
      logic        level_end;
      logic        tree_end;
      logic        overflowed;
   } rsp_payload_type;
endpackage
`default_nettype wire

@@ sv/wavelet_tree_level_builder_unit.sv @@
//------------------------------------------------------------------------------
// wavelet_tree_level_builder_unit
// Loads a symbol text, then emits a levelwise wavelet tree as packed bit words,
// doing a stable counting sort in memory between levels.
//------------------------------------------------------------------------------
//  channel  | direction | handshake
//  req_*    | in        | req_valid / req_ready, req_payload
//  rsp_*    | out       | rsp_valid / rsp_ready, rsp_payload
//  csr_*    | in        | csr_wr_en, csr_wr_data (alphabet_size)
// A fetch of an n-bit word reads one entry per cycle, and no new request is taken
// while it runs. After the last word of each level but the last, the block runs the
// sort. The first fetch also masks each symbol to its low h bits.
// Reset is synchronous; memories hold garbage until written and are not cleared.
// A stalled result blocks only new requests; the next request waits for it to drain.
//------------------------------------------------------------------------------
`default_nettype none
module wavelet_tree_level_builder_unit
   import wtlb_pkg::*;
#(
   parameter int MAX_TEXT_LEN = MaxTextLenDefault,
   parameter int SYMBOL_BITS  = SymbolBitsDefault,
   parameter int WORD_BITS    = WordBitsDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [CsrBits-1:0] csr_wr_data
);
   localparam int AW = $clog2(MAX_TEXT_LEN);
   localparam int LW = $clog2(MAX_TEXT_LEN + 1);
   localparam int NB = 1 << SYMBOL_BITS;
   localparam int BW = $clog2(NB);
   localparam int BCW = (BW < 1) ? 1 : BW;
   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int WIW = $clog2(WORD_BITS);
   localparam int HW = $clog2(SYMBOL_BITS + 1);
   localparam int IW = (LW > BCW + 1) ? LW : BCW + 1;

   typedef enum logic [10:0] {
      ST_LOAD  = 11'b00000000001,
      ST_MASK  = 11'b00000000010,
      ST_EMIT  = 11'b00000000100,
      ST_CLR   = 11'b00000001000,
      ST_HIST  = 11'b00000010000,
      ST_PSUM  = 11'b00000100000,
      ST_SCAT  = 11'b00001000000,
      ST_COPY  = 11'b00010000000,
      ST_RESP  = 11'b00100000000,
      ST_HWAIT = 11'b01000000000,
      ST_SWAIT = 11'b10000000000
   } state_type;

   // memories
   logic [SYMBOL_BITS-1:0] mem_a [MAX_TEXT_LEN];
   logic [SYMBOL_BITS-1:0] mem_b [MAX_TEXT_LEN];
   logic [LW-1:0]          mem_c [NB];
   logic [SYMBOL_BITS-1:0] a_rd_ff, b_rd_ff;
   logic [LW-1:0]          c_rd_ff;
   logic                   a_we, b_we, c_we;
   logic [AW-1:0]          a_wa, a_ra, b_wa, b_ra;
   logic [SYMBOL_BITS-1:0] a_wd, b_wd;
   logic [BCW-1:0]         c_wa, c_ra;
   logic [LW-1:0]          c_wd;

   always_ff @(posedge clock) begin
      if (a_we) mem_a[a_wa] <= a_wd;
      a_rd_ff <= mem_a[a_ra];
      if (b_we) mem_b[b_wa] <= b_wd;
      b_rd_ff <= mem_b[b_ra];
      if (c_we) mem_c[c_wa] <= c_wd;
      c_rd_ff <= mem_c[c_ra];
   end

   state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in, pos_ff, pos_in;
   logic [2:0] lvl_ff, lvl_in;
   logic ovf_ff, ovf_in;
   logic [CsrBits-1:0] asz_ff;
   logic [HW-1:0] h_ff, h_in;
   logic [IW-1:0] i_ff, i_in;       // sweep issue index
   logic          v_ff, v_in;       // read in flight
   logic [IW-1:0] j_ff, j_in;       // index of the data in flight
   logic [LW-1:0] sum_ff, sum_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BCW-1:0] key_ff, key_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic rv_ff, rv_in;
   rsp_payload_type rsp_ff, rsp_in;

   // height from alphabet size: bits of (size-1), clamped to 1..SYMBOL_BITS
   function automatic logic [HW-1:0] calc_h(input logic [CsrBits-1:0] s);
      logic [HW-1:0] h;
      h = HW'(1);
      for (int k = 1; k < SYMBOL_BITS; k++)
         if ((CsrBits'(1) << k) < s) h = HW'(k + 1);
      return h;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) asz_ff <= CsrBits'(256);
      else if (csr_wr_en && state_ff == ST_LOAD) asz_ff <= csr_wr_data;
   end

   logic [HW-1:0] shift_c;
   logic [SYMBOL_BITS-1:0] mask_c;
   logic [BCW-1:0] key_c;
   logic [LW-1:0] remain_c;
   logic [CW-1:0] take_c;
   logic [SYMBOL_BITS-1:0] a_src_sym;
   logic [SYMBOL_BITS-1:0] bit_sym_c;

   always_comb begin
      shift_c = h_ff - HW'(1) - HW'(lvl_ff);
      mask_c  = SYMBOL_BITS'((32'd1 << h_ff) - 32'd1);
      a_src_sym = a_rd_ff;
      key_c   = BCW'(a_src_sym >> shift_c);
      bit_sym_c = a_rd_ff >> shift_c;
      remain_c = len_ff - pos_ff;
      take_c  = (remain_c < LW'(WORD_BITS)) ? CW'(remain_c) : CW'(WORD_BITS);
   end

   always_comb begin
      state_in = state_ff; len_in = len_ff; pos_in = pos_ff; lvl_in = lvl_ff;
      ovf_in = ovf_ff; h_in = h_ff; i_in = i_ff; v_in = 1'b0; j_in = i_ff;
      sum_in = sum_ff; word_in = word_ff; cnt_in = cnt_ff; key_in = key_ff;
      sym_in = sym_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      a_we = 1'b0; a_wa = len_ff[AW-1:0]; a_wd = req_payload.symbol[SYMBOL_BITS-1:0];
      a_ra = i_ff[AW-1:0];
      b_we = 1'b0; b_wa = '0; b_wd = a_rd_ff; b_ra = i_ff[AW-1:0];
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            req_ready = !rv_ff;
            if (req_valid && req_ready) begin
               if (req_payload.operation == OP_LOAD) begin
                  if (len_ff < LW'(MAX_TEXT_LEN)) begin
                     a_we = 1'b1;
                     len_in = len_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (len_ff == '0) begin
                  rsp_in = '0;
                  rsp_in.level_end = 1'b1; rsp_in.tree_end = 1'b1;
                  rsp_in.overflowed = ovf_ff;
                  rv_in = 1'b1; ovf_in = 1'b0;
               end else begin
                  h_in = calc_h(asz_ff);
                  lvl_in = '0; pos_in = '0; i_in = '0;
                  state_in = ST_MASK;
               end
            end
         end
         ST_MASK: begin
            // read, mask, write back one entry per cycle
            a_ra = i_ff[AW-1:0];
            if (i_ff < IW'(len_ff)) begin
               v_in = 1'b1; i_in = i_ff + IW'(1);
            end
            if (v_ff) begin
               a_we = 1'b1; a_wa = j_ff[AW-1:0]; a_wd = a_rd_ff & mask_c;
            end
            if (!v_ff && i_ff >= IW'(len_ff)) begin
               state_in = ST_EMIT; i_in = IW'(pos_ff); word_in = '0; cnt_in = '0;
            end
         end
         ST_EMIT: begin
            a_ra = i_ff[AW-1:0];
            if (i_ff < IW'(pos_ff) + IW'(take_c)) begin
               v_in = 1'b1; i_in = i_ff + IW'(1);
            end
            if (v_ff) begin
               word_in[cnt_ff[WIW-1:0]] = bit_sym_c[0];
               cnt_in = cnt_ff + CW'(1);
            end
            if (!v_ff && i_ff >= IW'(pos_ff) + IW'(take_c)) begin
               rsp_in.bit_word = 64'(word_ff);
               rsp_in.bit_count = 7'(take_c);
               rsp_in.tree_level = lvl_ff;
               rsp_in.overflowed = ovf_ff;
               rsp_in.level_end = (pos_ff + LW'(take_c) >= len_ff);
               rsp_in.tree_end = rsp_in.level_end && (HW'(lvl_ff) + HW'(1) >= h_ff);
               pos_in = pos_ff + LW'(take_c);
               if (rsp_in.tree_end) begin
                  rv_in = 1'b1; state_in = ST_LOAD;
                  len_in = '0; lvl_in = '0; pos_in = '0; ovf_in = 1'b0;
               end else if (rsp_in.level_end) begin
                  rv_in = 1'b1; state_in = ST_CLR; i_in = '0;
               end else begin
                  rv_in = 1'b1; state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            req_ready = !rv_ff;
            if (req_valid && req_ready && req_payload.operation == OP_FETCH) begin
               state_in = ST_EMIT; i_in = IW'(pos_ff); word_in = '0; cnt_in = '0;
            end
         end
         ST_CLR: begin
            c_we = 1'b1; c_wa = i_ff[BCW-1:0]; c_wd = '0;
            i_in = i_ff + IW'(1);
            if (i_ff == IW'(NB - 1)) begin state_in = ST_HIST; i_in = '0; end
         end
         ST_HIST: begin
            // read symbol, then read bucket, then increment
            a_ra = i_ff[AW-1:0];
            if (i_ff < IW'(len_ff)) begin v_in = 1'b1; i_in = i_ff + IW'(1); end
            if (v_ff) begin c_ra = key_c; key_in = key_c; state_in = ST_HWAIT;
               v_in = 1'b0; i_in = i_ff; end
            else if (i_ff >= IW'(len_ff)) begin
               state_in = ST_PSUM; i_in = '0; sum_in = '0;
            end
         end
         ST_HWAIT: begin
            c_we = 1'b1; c_wa = key_ff; c_wd = c_rd_ff + LW'(1);
            state_in = ST_HIST;
         end
         ST_PSUM: begin
            c_ra = i_ff[BCW-1:0];
            if (i_ff < IW'(NB)) begin v_in = 1'b1; i_in = i_ff + IW'(1); end
            if (v_ff) begin
               c_we = 1'b1; c_wa = j_ff[BCW-1:0]; c_wd = sum_ff;
               sum_in = sum_ff + c_rd_ff;
            end
            if (!v_ff && i_ff >= IW'(NB)) begin state_in = ST_SCAT; i_in = '0; end
         end
         ST_SCAT: begin
            a_ra = i_ff[AW-1:0];
            if (i_ff < IW'(len_ff)) begin v_in = 1'b1; i_in = i_ff + IW'(1); end
            if (v_ff) begin
               c_ra = key_c; key_in = key_c; sym_in = a_rd_ff;
               state_in = ST_SWAIT; v_in = 1'b0; i_in = i_ff;
            end else if (i_ff >= IW'(len_ff)) begin
               state_in = ST_COPY; i_in = '0;
            end
         end
         ST_SWAIT: begin
            b_we = 1'b1; b_wa = c_rd_ff[AW-1:0]; b_wd = sym_ff;
            c_we = 1'b1; c_wa = key_ff; c_wd = c_rd_ff + LW'(1);
            state_in = ST_SCAT;
         end
         ST_COPY: begin
            b_ra = i_ff[AW-1:0];
            if (i_ff < IW'(len_ff)) begin v_in = 1'b1; i_in = i_ff + IW'(1); end
            if (v_ff) begin a_we = 1'b1; a_wa = j_ff[AW-1:0]; a_wd = b_rd_ff; end
            if (!v_ff && i_ff >= IW'(len_ff)) begin
               lvl_in = lvl_ff + 3'd1; pos_in = '0; state_in = ST_RESP;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; len_ff <= '0; pos_ff <= '0; lvl_ff <= '0;
         ovf_ff <= 1'b0; rv_ff <= 1'b0; v_ff <= 1'b0;
         h_ff <= HW'(1);
      end else begin
         state_ff <= state_in; len_ff <= len_in; pos_ff <= pos_in; lvl_ff <= lvl_in;
         ovf_ff <= ovf_in; rv_ff <= rv_in; v_ff <= v_in;
         h_ff <= h_in;
      end
      i_ff <= i_in; j_ff <= j_in; sum_ff <= sum_in; word_ff <= word_in;
      cnt_ff <= cnt_in; key_ff <= key_in; sym_ff <= sym_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

`include "wavelet_tree_level_builder_unit_assert.svh"
   `WTLB_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !rsp_valid,
      "request taken while result pending")
   `WTLB_ASSERT_IMPL(a_cnt_rng, clock, reset, rsp_valid,
      rsp_payload.bit_count <= 7'(WORD_BITS), "bit count out of range")
   `WTLB_ASSERT_IMPL(a_tree_lvl, clock, reset, rsp_valid && rsp_payload.tree_end,
      rsp_payload.level_end, "tree end without level end")
   `WTLB_ASSERT_NEXT(a_len_cap, clock, reset, 1'b1, len_ff <= LW'(MAX_TEXT_LEN),
      "text length over capacity")
endmodule
`default_nettype wire
